// ===== hdl/vts_pkg.sv =====
// shared types and constants of the vario tone sequencer
package vts_pkg;

  // input item kinds
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_BASE_FREQ = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INT_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHIRP_LO  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHIRP_HI  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WATCHDOG  = 3'd4;
  localparam int CfgDataW = 12;

  // reset values of the configuration registers
  localparam logic [11:0] BASE_FREQ_RST = 12'd300;
  localparam logic [10:0] INT_LIMIT_RST = 11'd1000;
  localparam logic [11:0] CHIRP_LO_RST  = 12'd500;
  localparam logic [11:0] CHIRP_HI_RST  = 12'd3000;
  localparam logic [6:0]  WATCHDOG_RST  = 7'd100;

  // pitch handling: offset, then divide by 12 as multiply by ceil(2^19/12)
  localparam logic signed [16:0] PITCH_OFFSET = 17'sd10000;
  localparam logic [15:0] DIV12_RECIP = 16'd43691;
  localparam int DIV12_SHIFT = 19;

  localparam logic [10:0] VOL_MAX = 11'd100;

  // gating windows
  localparam logic [15:0] GATE_INTERVAL_MIN = 16'd10;
  localparam logic [4:0]  VARIO_GATE_WRAP   = 5'd20;
  localparam logic [4:0]  VARIO_GATE_ON     = 5'd10;
  localparam logic [4:0]  CRUISE_GATE_WRAP  = 5'd15;
  localparam logic [4:0]  CRUISE_GATE_ON    = 5'd5;

  typedef enum logic [1:0] {
    CHIRP_STOPPED = 2'd0,
    CHIRP_DOWN    = 2'd1,
    CHIRP_UP      = 2'd2
  } chirp_mode_t;

  // percent * 65536 / 100 for percent <= 100:
  // percent*655 + floor(percent*9/25), the last via *41 >> 10
  function automatic logic [16:0] vol_scale(input logic [6:0] pct);
    logic [9:0]  x9;
    logic [15:0] q;
    logic [16:0] whole;
    x9    = 10'({3'b0, pct} * 10'd9);
    q     = 16'({6'b0, x9} * 16'd41);
    whole = 17'({10'b0, pct} * 17'd655);
    return whole + {11'b0, q[15:10]};
  endfunction

endpackage

// ===== hdl/vario_tone_sequencer.sv =====
// vario tone sequencer: settings packets and ticks in, tone settings out
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | opcode, pitch, interval, volume, mode, error
//  out_    | output    | out_valid / out_stall | tone frequency, volume level, enable
//  cfg_    | input     | cfg_valid / cfg_ready | register index, write data
//
// an item is worked off while it sits in the input register: its state update and
// a tick's result are registered as it leaves, so a result beat is offered from the
// output register; one item is taken every cycle unless out_stall holds a tick
// rst_n is synchronous; it restores the register defaults and clears the block
// state and the valid flags; out_stall holds a tick in the input register and
// so stalls the input side; packets pass a stalled output since they give no result
module vario_tone_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic signed [15:0]               in_pitch_word,
  input  logic [15:0]                      in_interval_word,
  input  logic [7:0]                       in_volume_step,
  input  logic [7:0]                       in_climb_mode,
  input  logic signed [7:0]                in_speed_error_raw,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [12:0]                      out_tone_frequency_hz,
  output logic [16:0]                      out_volume_level,
  output logic                             out_sound_enable,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vts_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [vts_pkg::CfgDataW-1:0]     cfg_data
);
  import vts_pkg::*;

  // configuration
  logic [11:0] base_freq_r, chirp_lo_r, chirp_hi_r;
  logic [10:0] int_limit_r;
  logic [6:0]  watchdog_ticks_r;

  // input register
  logic               s1_valid_r, s1_op_r;
  logic signed [15:0] s1_pitch_r;
  logic [15:0]        s1_interval_r;
  logic [7:0]         s1_volume_r, s1_climb_r, s1_speed_r;

  // block state
  logic [11:0]  pitch_div_r, pitch_div_nxt;
  logic [15:0]  interval_r, interval_nxt;
  logic [6:0]   vol_pct_r, vol_pct_nxt;
  logic [7:0]   climb_r, climb_nxt;
  logic [7:0]   speed_err_r, speed_err_nxt;
  logic [6:0]   wdog_r, wdog_nxt;
  logic [11:0]  integ_r, integ_nxt;
  chirp_mode_t  chirp_mode_r, chirp_mode_nxt;
  logic [12:0]  chirp_freq_r, chirp_freq_nxt;
  logic [7:0]   chirp_inc_r, chirp_inc_nxt;
  logic [4:0]   gate_r, gate_nxt;

  // output register
  logic        out_valid_r;
  logic [12:0] out_freq_r;
  logic [16:0] out_level_r;
  logic        out_en_r;

  logic advance, out_free, s1_load;

  // packet datapath
  logic signed [16:0] pitch_sum;
  logic [15:0]        pitch_clamp;
  logic [31:0]        pitch_prod;
  logic [10:0]        vol_x5;

  // tick datapath
  logic [6:0]         wdog_dec;
  logic signed [7:0]  err_s;
  logic signed [12:0] int_sum, lim_s;
  logic signed [13:0] chirp_f, chirp_step;
  logic [12:0]        tick_freq;
  logic [4:0]         gate_inc;
  logic               tick_mute;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (s1_op_r == OP_PACKET || out_free);
  assign s1_load  = !s1_valid_r || advance;
  assign in_stall = s1_valid_r && !advance;
  assign cfg_ready = !s1_valid_r;

  assign out_valid             = out_valid_r;
  assign out_tone_frequency_hz = out_freq_r;
  assign out_volume_level      = out_level_r;
  assign out_sound_enable      = out_en_r;

  // packet: offset and clamp the pitch, then divide by 12
  assign pitch_sum   = {s1_pitch_r[15], s1_pitch_r} + PITCH_OFFSET;
  assign pitch_clamp = pitch_sum[16] ? 16'd0 : pitch_sum[15:0];
  assign pitch_prod  = pitch_clamp * DIV12_RECIP;
  assign vol_x5      = 11'({3'b0, s1_volume_r} * 11'd5);
  assign wdog_dec    = (wdog_r != 7'd0) ? wdog_r - 7'd1 : 7'd0;

  always_comb begin
    pitch_div_nxt  = pitch_div_r;
    interval_nxt   = interval_r;
    vol_pct_nxt    = vol_pct_r;
    climb_nxt      = climb_r;
    speed_err_nxt  = speed_err_r;
    wdog_nxt       = wdog_r;
    integ_nxt      = integ_r;
    chirp_mode_nxt = chirp_mode_r;
    chirp_freq_nxt = chirp_freq_r;
    chirp_inc_nxt  = chirp_inc_r;
    gate_nxt       = gate_r;
    tick_freq      = 13'd0;
    tick_mute      = 1'b1;
    err_s          = signed'(speed_err_r);
    int_sum        = 13'(signed'(integ_r)) + 13'(err_s);
    lim_s          = signed'({2'b0, int_limit_r});
    chirp_f        = 14'sd0;
    chirp_step     = 14'sd0;
    gate_inc       = gate_r + 5'd1;

    if (s1_op_r == OP_PACKET) begin
      pitch_div_nxt = pitch_prod[DIV12_SHIFT +: 12];
      interval_nxt  = s1_interval_r;
      vol_pct_nxt   = (vol_x5 > VOL_MAX) ? VOL_MAX[6:0] : vol_x5[6:0];
      climb_nxt     = s1_climb_r;
      speed_err_nxt = 8'(~s1_speed_r + 8'd1);
      wdog_nxt      = watchdog_ticks_r;
    end else begin
      wdog_nxt = wdog_dec;
      if (wdog_dec == 7'd0) begin
        vol_pct_nxt = 7'd0;
      end else if (vol_pct_r != 7'd0) begin
        tick_mute = 1'b0;
        if (climb_r != 8'd0) begin
          tick_freq = {1'b0, base_freq_r} + {1'b0, pitch_div_r};
          if (interval_r > GATE_INTERVAL_MIN) begin
            if (gate_inc > VARIO_GATE_WRAP) gate_inc = 5'd0;
            gate_nxt = gate_inc;
            if (gate_inc > VARIO_GATE_ON) tick_freq = 13'd0;
          end
        end else begin
          // integrator past the limit starts a chirp, a running one in the same direction is kept
          if (int_sum > lim_s) begin
            if (chirp_mode_r != CHIRP_DOWN) begin
              chirp_freq_nxt = {1'b0, chirp_hi_r};
              chirp_inc_nxt  = speed_err_r;
            end
            chirp_mode_nxt = CHIRP_DOWN;
            int_sum = 13'sd0;
          end else if (int_sum < -lim_s) begin
            if (chirp_mode_r != CHIRP_UP) begin
              chirp_freq_nxt = {1'b0, chirp_lo_r};
              chirp_inc_nxt  = speed_err_r;
            end
            chirp_mode_nxt = CHIRP_UP;
            int_sum = 13'sd0;
          end
          integ_nxt = int_sum[11:0];

          chirp_step = 14'(signed'(chirp_inc_nxt));
          chirp_f    = signed'({1'b0, chirp_freq_nxt});
          case (chirp_mode_nxt)
            CHIRP_UP: begin
              chirp_f = chirp_f - chirp_step;
            end
            CHIRP_DOWN: begin
              chirp_f = chirp_f - (chirp_step >>> 1);
            end
            default: begin
              chirp_f = 14'sd0;
            end
          endcase
          if (chirp_mode_nxt == CHIRP_UP || chirp_mode_nxt == CHIRP_DOWN) begin
            // chirp ends as soon as it leaves the window
            if (chirp_f > signed'({2'b0, chirp_hi_r}) ||
                chirp_f < signed'({2'b0, chirp_lo_r})) begin
              chirp_f        = 14'sd0;
              chirp_mode_nxt = CHIRP_STOPPED;
              chirp_inc_nxt  = 8'd0;
            end
          end
          chirp_freq_nxt = chirp_f[12:0];
          tick_freq      = chirp_f[12:0];

          if (err_s > 8'sd0) begin
            if (gate_inc > CRUISE_GATE_WRAP) gate_inc = 5'd0;
            gate_nxt = gate_inc;
            if (gate_inc > CRUISE_GATE_ON) tick_freq = 13'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_freq_r      <= BASE_FREQ_RST;
      int_limit_r      <= INT_LIMIT_RST;
      chirp_lo_r       <= CHIRP_LO_RST;
      chirp_hi_r       <= CHIRP_HI_RST;
      watchdog_ticks_r <= WATCHDOG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_FREQ: base_freq_r      <= cfg_data[11:0];
        CFG_INT_LIMIT: int_limit_r      <= cfg_data[10:0];
        CFG_CHIRP_LO:  chirp_lo_r       <= cfg_data[11:0];
        CFG_CHIRP_HI:  chirp_hi_r       <= cfg_data[11:0];
        CFG_WATCHDOG:  watchdog_ticks_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
    if (s1_load && in_valid) begin
      s1_op_r       <= in_opcode;
      s1_pitch_r    <= in_pitch_word;
      s1_interval_r <= in_interval_word;
      s1_volume_r   <= in_volume_step;
      s1_climb_r    <= in_climb_mode;
      s1_speed_r    <= in_speed_error_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_div_r  <= 12'd0;
      interval_r   <= 16'd0;
      vol_pct_r    <= 7'd0;
      climb_r      <= 8'd0;
      speed_err_r  <= 8'd0;
      wdog_r       <= 7'd0;
      integ_r      <= 12'd0;
      chirp_mode_r <= CHIRP_STOPPED;
      chirp_freq_r <= 13'd0;
      chirp_inc_r  <= 8'd0;
      gate_r       <= 5'd0;
    end else if (advance) begin
      pitch_div_r  <= pitch_div_nxt;
      interval_r   <= interval_nxt;
      vol_pct_r    <= vol_pct_nxt;
      climb_r      <= climb_nxt;
      speed_err_r  <= speed_err_nxt;
      wdog_r       <= wdog_nxt;
      integ_r      <= integ_nxt;
      chirp_mode_r <= chirp_mode_nxt;
      chirp_freq_r <= chirp_freq_nxt;
      chirp_inc_r  <= chirp_inc_nxt;
      gate_r       <= gate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && s1_op_r == OP_TICK;
    end
    if (out_free && advance && s1_op_r == OP_TICK) begin
      if (tick_mute || tick_freq == 13'd0) begin
        out_freq_r  <= 13'd0;
        out_level_r <= 17'd0;
        out_en_r    <= 1'b0;
      end else begin
        out_freq_r  <= tick_freq;
        out_level_r <= vol_scale(vol_pct_r);
        out_en_r    <= 1'b1;
      end
    end
  end

  // an enabled beat always carries a tone and a volume
  a_enable_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_en_r |-> out_freq_r != 13'd0 && out_level_r != 17'd0)
    else $error("sound enabled with empty tone");

  // a tick that runs the watchdog out gives a silent beat
  a_watchdog_mute: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_op_r == OP_TICK && wdog_r <= 7'd1 |=> out_valid_r && !out_en_r)
    else $error("tick after watchdog expiry not muted");

  // volume stays within percent range
  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    vol_pct_r <= VOL_MAX[6:0])
    else $error("volume percent out of range");

  // a stalled input always has an item waiting in the input register
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_op_r == OP_TICK && out_valid_r)
    else $error("input stalled without a blocked tick");

endmodule

// ===== dv/vts_checker.sv =====
`timescale 1ns / 100ps
// tone checker: predicts the result of every tick beat and compares it with the output beat
module vts_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_opcode,
  input  logic signed [15:0]          in_pitch_word,
  input  logic [15:0]                 in_interval_word,
  input  logic [7:0]                  in_volume_step,
  input  logic [7:0]                  in_climb_mode,
  input  logic signed [7:0]           in_speed_error_raw,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [12:0]                 out_tone_frequency_hz,
  input  logic [16:0]                 out_volume_level,
  input  logic                        out_sound_enable,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [vts_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [vts_pkg::CfgDataW-1:0] cfg_data,
  output int                          errors,
  output int                          pending
);
  import vts_pkg::*;

  typedef struct packed {
    logic [12:0] freq;
    logic [16:0] level;
    logic        on;
  } tone_t;

  tone_t tone_due[$];
  int    ticks_seen;

  // register copies
  logic [11:0] base_hz, chirp_lo, chirp_hi;
  logic [10:0] int_limit;
  logic [6:0]  wd_reload;

  // latched settings and running state
  logic [15:0] pitch_l, interval_l;
  logic [6:0]  vol_pct, wd_left;
  logic [7:0]  climb_l, serr_l, chirp_inc;
  logic [4:0]  gate;
  int          integ, chirp_hz;
  chirp_mode_t chirp_st;

  task automatic flag(input string msg);
    $display("vts_checker: %s", msg);
    errors++;
  endtask

  function automatic void start_chirp(input chirp_mode_t m);
    // a running chirp of the same direction keeps its frequency and increment
    if (chirp_st != m) begin
      chirp_hz  = (m == CHIRP_UP) ? int'(chirp_lo) : int'(chirp_hi);
      chirp_inc = serr_l;
    end
    chirp_st = m;
  endfunction

  function automatic tone_t tick_tone();
    int    f, err, sum, inc_v;
    tone_t t;
    f = 0;
    t = '0;
    if (wd_left != 0) wd_left--;
    if (wd_left == 0) begin
      vol_pct = '0;
      return t;
    end
    if (vol_pct == 0) return t;
    if (climb_l != 0) begin
      f = int'(base_hz) + int'(pitch_l) / 12;
      if (interval_l > GATE_INTERVAL_MIN) begin
        gate++;
        if (gate > VARIO_GATE_WRAP) gate = '0;
        if (gate > VARIO_GATE_ON) f = 0;
      end
    end else begin
      err = int'(signed'(serr_l));
      // sum is checked at full width before it is stored
      sum = integ + err;
      if (sum > int'(int_limit)) begin
        start_chirp(CHIRP_DOWN);
        sum = 0;
      end else if (sum < -int'(int_limit)) begin
        start_chirp(CHIRP_UP);
        sum = 0;
      end
      integ = sum;
      inc_v = int'(signed'(chirp_inc));
      if (chirp_st == CHIRP_STOPPED) begin
        chirp_hz = 0;
      end else begin
        if (chirp_st == CHIRP_UP) chirp_hz -= inc_v;
        else chirp_hz -= inc_v >>> 1;
        if (chirp_hz > int'(chirp_hi) || chirp_hz < int'(chirp_lo)) begin
          chirp_hz  = 0;
          chirp_st  = CHIRP_STOPPED;
          chirp_inc = '0;
        end
      end
      f = chirp_hz;
      if (err > 0) begin
        gate++;
        if (gate > CRUISE_GATE_WRAP) gate = '0;
        if (gate > CRUISE_GATE_ON) f = 0;
      end
    end
    if (f != 0) begin
      t.freq  = f[12:0];
      t.level = 17'(int'(vol_pct) * 65536 / 100);
      t.on    = 1'b1;
    end
    return t;
  endfunction

  always @(posedge clk) begin : watch
    tone_t want;
    int    p, v;
    if (!rst_n) begin
      base_hz    = BASE_FREQ_RST;
      int_limit  = INT_LIMIT_RST;
      chirp_lo   = CHIRP_LO_RST;
      chirp_hi   = CHIRP_HI_RST;
      wd_reload  = WATCHDOG_RST;
      pitch_l    = '0;
      interval_l = '0;
      vol_pct    = '0;
      climb_l    = '0;
      serr_l     = '0;
      wd_left    = '0;
      integ      = 0;
      chirp_st   = CHIRP_STOPPED;
      chirp_hz   = 0;
      chirp_inc  = '0;
      gate       = '0;
      ticks_seen = 0;
      tone_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_FREQ: base_hz = cfg_data[11:0];
          CFG_INT_LIMIT: int_limit = cfg_data[10:0];
          CFG_CHIRP_LO:  chirp_lo = cfg_data[11:0];
          CFG_CHIRP_HI:  chirp_hi = cfg_data[11:0];
          CFG_WATCHDOG:  wd_reload = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (tone_due.size() == 0) begin
          flag($sformatf("result beat with no tick waiting (freq %0d)", out_tone_frequency_hz));
        end else begin
          want = tone_due.pop_front();
          if (out_tone_frequency_hz !== want.freq)
            flag($sformatf("tick %0d: frequency %0d, predicted %0d",
                           ticks_seen, out_tone_frequency_hz, want.freq));
          if (out_volume_level !== want.level)
            flag($sformatf("tick %0d: volume level %0d, predicted %0d",
                           ticks_seen, out_volume_level, want.level));
          if (out_sound_enable !== want.on)
            flag($sformatf("tick %0d: sound enable %0b, predicted %0b",
                           ticks_seen, out_sound_enable, want.on));
        end
        ticks_seen++;
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_PACKET) begin
          p          = int'(in_pitch_word) + int'(PITCH_OFFSET);
          pitch_l    = (p < 0) ? 16'd0 : p[15:0];
          interval_l = in_interval_word;
          v          = int'(in_volume_step) * 5;
          vol_pct    = (v > int'(VOL_MAX)) ? 7'(VOL_MAX) : 7'(v);
          climb_l    = in_climb_mode;
          serr_l     = 8'(8'd0 - in_speed_error_raw);
          wd_left    = wd_reload;
        end else begin
          tone_due.push_back(tick_tone());
        end
      end
    end
    pending = tone_due.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench top: drives packets, ticks and register writes into the tone sequencer
module tb;
  import vts_pkg::*;

  localparam int N_PHASES       = 9;
  localparam int RAND_PER_PHASE = 145;
  localparam int HOLD_LEN       = 120;
  localparam int CYCLE_LIMIT    = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_opcode = OP_PACKET;
  logic signed [15:0]   in_pitch_word = '0;
  logic [15:0]          in_interval_word = '0;
  logic [7:0]           in_volume_step = '0;
  logic [7:0]           in_climb_mode = '0;
  logic signed [7:0]    in_speed_error_raw = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [12:0]          out_tone_frequency_hz;
  logic [16:0]          out_volume_level;
  logic                 out_sound_enable;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = CFG_BASE_FREQ;
  logic [CfgDataW-1:0]  cfg_data = '0;

  int   errors, pending;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   hold_left = 0;
  logic hold_go = 1'b0;
  int   cycles = 0;

  always #4 clk = ~clk;

  vario_tone_sequencer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_pitch_word         (in_pitch_word),
    .in_interval_word      (in_interval_word),
    .in_volume_step        (in_volume_step),
    .in_climb_mode         (in_climb_mode),
    .in_speed_error_raw    (in_speed_error_raw),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_tone_frequency_hz (out_tone_frequency_hz),
    .out_volume_level      (out_volume_level),
    .out_sound_enable      (out_sound_enable),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  vts_checker chk (.*);

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input logic [15:0] pitch, input logic [15:0] interval,
                           input logic [7:0] vol, input logic [7:0] mode, input logic [7:0] serr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_pitch_word      <= pitch;
    in_interval_word   <= interval;
    in_volume_step     <= vol;
    in_climb_mode      <= mode;
    in_speed_error_raw <= serr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // tick beats carry junk in the unused fields
  task automatic send_ticks(input int n);
    repeat (n)
      send_beat(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
  endtask

  task automatic load_regs(input logic [11:0] base, input logic [10:0] lim,
                           input logic [11:0] lo, input logic [11:0] hi, input logic [6:0] wd);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] vals [5];
    idx  = '{CFG_BASE_FREQ, CFG_INT_LIMIT, CFG_CHIRP_LO, CFG_CHIRP_HI, CFG_WATCHDOG};
    vals = '{base, 12'(lim), lo, hi, 12'(wd)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // let every tick drain, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int          sent, kind, r;
    logic [7:0]  serr;
    logic [11:0] lo;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      tx_idle_pct = (ph < 3) ? 19 : (ph < 6) ? 82 : 0;
      rx_idle_pct = (ph < 3) ? 82 : (ph < 6) ? 19 : 0;
      drain();
      lo = 12'($urandom_range(0, 1500));
      case (ph)
        0: load_regs(BASE_FREQ_RST, INT_LIMIT_RST, CHIRP_LO_RST, CHIRP_HI_RST, WATCHDOG_RST);
        1: load_regs(12'd0, 11'd1, 12'd0, 12'd4095, 7'd127);
        2: load_regs(12'd4095, 11'd2047, 12'd100, 12'd400, 7'd30);
        // zero limit, and a window with low above high
        4: load_regs(12'($urandom), 11'd0, 12'd800, 12'd200, 7'd60);
        // zero watchdog keeps everything muted
        5: load_regs(12'($urandom), 11'($urandom_range(1, 2047)), lo, 12'd3500, 7'd0);
        6: load_regs(12'd1234, 11'd5, 12'd300, 12'd3500, 7'd2);
        default: load_regs(12'($urandom), 11'($urandom_range(1, 2047)), lo,
                           12'($urandom_range(1500, 4095)), 7'($urandom_range(1, 127)));
      endcase

      if (ph == 0) begin
        send_beat(OP_PACKET, 16'h7fff, 16'hffff, 8'hff, 8'hff, 8'h80);
        send_ticks(2);
        send_beat(OP_PACKET, 16'h8000, 16'd0, 8'd0, 8'd1, 8'h7f);
        send_ticks(1);
        send_beat(OP_PACKET, 16'(-10000), 16'd10, 8'd1, 8'd1, 8'd0);
        send_ticks(1);
        // cruise: integrator runs past the limit and an up sweep starts
        send_beat(OP_PACKET, 16'd0, 16'd11, 8'd20, 8'd0, 8'h80);
        send_ticks(10);
        send_beat(OP_PACKET, 16'd0, 16'd0, 8'hff, 8'd0, 8'h7f);
        send_ticks(3);
      end

      if (ph == N_PHASES - 1) hold_go = 1'b1;

      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        kind = $urandom_range(99);
        if (kind < 80) begin
          r = $urandom_range(9);
          if (r == 0) serr = 8'd0;
          else if (r < 3) serr = 8'($urandom);
          else serr = 8'($urandom_range(0, 160)) - 8'd80;
          send_beat(OP_PACKET, 16'($urandom),
                    $urandom_range(1) ? 16'($urandom_range(0, 20)) : 16'($urandom),
                    ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)),
                    $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 255)), serr);
          r = $urandom_range(1, 40);
          send_ticks(r);
          sent += r + 1;
        end else if (kind < 90) begin
          // long tick run, lets the watchdog expire
          r = $urandom_range(40, 140);
          send_ticks(r);
          sent += r;
        end else begin
          send_beat(OP_PACKET, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
          sent++;
        end
      end
    end

    drain();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
